// ----- hw/rtl/fjsp_pkg.sv -----
// fjsp_pkg: phase codes, character constants, the result word type and
// byte helpers for the flat string-pair parser; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package fjsp_pkg;

   localparam logic [3:0] PH_SEEK_BRACE = 4'd0;
   localparam logic [3:0] PH_PRE_KEY    = 4'd1;
   localparam logic [3:0] PH_KEY_SEEK   = 4'd2;
   localparam logic [3:0] PH_KEY        = 4'd3;
   localparam logic [3:0] PH_KEY_ESC    = 4'd4;
   localparam logic [3:0] PH_PRE_VAL    = 4'd5;
   localparam logic [3:0] PH_VAL_SEEK   = 4'd6;
   localparam logic [3:0] PH_VAL        = 4'd7;
   localparam logic [3:0] PH_VAL_ESC    = 4'd8;
   localparam logic [3:0] PH_DONE       = 4'd9;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   typedef struct packed {
      logic [7:0] char_code;
      logic       char_valid;
      logic       in_value;
      logic       pair_end;
      logic       message_end;
      logic       last_of_run;
   } rsp_word_type;

   function automatic logic [7:0] unescape(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         CH_N:    r = CH_LF;
         CH_R:    r = CH_CR;
         CH_T:    r = CH_TAB;
         default: r = b;
      endcase
      return r;
   endfunction

   function automatic logic is_ws(input logic [7:0] b);
      return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/flat_json_string_pair_parser.sv -----
// flat_json_string_pair_parser: byte-wide parser for flat objects of quoted
// string keys and values; depends on fjsp_pkg
//
//  channel | direction | ports                                  | per word
//  --------+-----------+----------------------------------------+-------------------
//  req     | in        | req_valid, req_stall, req_in_byte,     | one message byte
//          |           | req_final_byte                         |
//  rsp     | out       | rsp_valid, rsp_stall, rsp_char_code..  | char or marker
//
//  one byte is taken per cycle while req_stall is low; the phase logic runs in the
//  accept cycle and writes zero, one or two result words into a 4-word output queue
//  a byte that yields two words needs two output reads, so with rsp_stall low the
//  sustained rate is one byte per cycle when each byte yields at most one word
//  req_stall rises while fewer than two queue slots are free
//  synchronous reset returns the parser to brace search and empties the queue
`timescale 1ns / 1ps
`default_nettype none

module flat_json_string_pair_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_final_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_char_code,
   output logic            rsp_char_valid,
   output logic            rsp_in_value,
   output logic            rsp_pair_end,
   output logic            rsp_message_end,
   output logic            rsp_last_of_run
);
   import fjsp_pkg::*;

   // parser state
   logic [3:0] phase_ff, phase_in;
   logic       khc_ff, khc_in;

   // output queue: 4 words, two may be written per cycle
   rsp_word_type queue_ff [4];
   logic [1:0]   wr_ptr_ff, wr_ptr_in;
   logic [1:0]   rd_ptr_ff, rd_ptr_in;
   logic [2:0]   count_ff, count_in;

   logic         req_take, rsp_take;
   logic [7:0]   b;
   logic         fin;
   logic         ch_ok, ch_val, pe, me;
   logic [7:0]   ch;
   logic         was_done;
   logic [3:0]   ph_mid;
   logic         khc_mid;
   logic         marker;
   rsp_word_type word0, word1;
   logic [1:0]   n_push;

   assign req_stall = (count_ff > 3'd2);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign b   = req_in_byte;
   assign fin = req_final_byte;

   // phase step for one byte
   always_comb begin
      ch_ok    = 1'b0;
      ch_val   = 1'b0;
      ch       = 8'd0;
      pe       = 1'b0;
      me       = 1'b0;
      ph_mid   = phase_ff;
      khc_mid  = khc_ff;
      was_done = (phase_ff >= PH_DONE);
      case (phase_ff)
         PH_SEEK_BRACE: begin
            if (b == CH_LBRACE) ph_mid = PH_PRE_KEY;
         end
         PH_PRE_KEY: begin
            if (!(is_ws(b) || b == CH_COMMA)) begin
               khc_mid = 1'b0;
               if (b == CH_RBRACE) begin
                  me     = 1'b1;
                  ph_mid = PH_DONE;
               end else if (b == CH_QUOTE) begin
                  ph_mid = PH_KEY;
               end else begin
                  ph_mid = PH_KEY_SEEK;
               end
            end
         end
         PH_KEY_SEEK: begin
            if (b == CH_QUOTE) begin
               khc_mid = 1'b0;
               ph_mid  = PH_KEY;
            end
         end
         PH_KEY: begin
            if (b == CH_QUOTE) begin
               // empty key closes the message without a pair
               if (khc_ff) ph_mid = PH_PRE_VAL;
               else begin
                  me     = 1'b1;
                  ph_mid = PH_DONE;
               end
            end else if (b == CH_BSLASH && !fin) begin
               ph_mid = PH_KEY_ESC;
            end else begin
               ch_ok   = 1'b1;
               ch      = b;
               khc_mid = 1'b1;
            end
         end
         PH_KEY_ESC: begin
            ch_ok   = 1'b1;
            ch      = unescape(b);
            khc_mid = 1'b1;
            ph_mid  = PH_KEY;
         end
         PH_PRE_VAL: begin
            if (!(is_ws(b) || b == CH_COLON))
               ph_mid = (b == CH_QUOTE) ? PH_VAL : PH_VAL_SEEK;
         end
         PH_VAL_SEEK: begin
            if (b == CH_QUOTE) ph_mid = PH_VAL;
         end
         PH_VAL: begin
            if (b == CH_QUOTE) begin
               pe      = 1'b1;
               khc_mid = 1'b0;
               ph_mid  = PH_PRE_KEY;
            end else if (b == CH_BSLASH && !fin) begin
               ph_mid = PH_VAL_ESC;
            end else begin
               ch_ok  = 1'b1;
               ch     = b;
               ch_val = 1'b1;
            end
         end
         PH_VAL_ESC: begin
            ch_ok  = 1'b1;
            ch     = unescape(b);
            ch_val = 1'b1;
            ph_mid = PH_VAL;
         end
         default: begin
            // finished: bytes are dropped until the final one
         end
      endcase

      phase_in = ph_mid;
      khc_in   = khc_mid;
      if (fin) begin
         // end of input ends the message unless already done, with any pending pair
         if (!was_done && !me) begin
            me = 1'b1;
            if ((((ph_mid == PH_KEY) || (ph_mid == PH_KEY_ESC)) && khc_mid) ||
                ((ph_mid >= PH_PRE_VAL) && (ph_mid <= PH_VAL_ESC)))
               pe = 1'b1;
         end
         phase_in = PH_SEEK_BRACE;
         khc_in   = 1'b0;
      end
   end

   // result words: char word first, marker word second
   always_comb begin
      marker = pe || me;
      word1  = '{char_code: 8'd0, char_valid: 1'b0, in_value: 1'b0,
                 pair_end: pe, message_end: me, last_of_run: 1'b1};
      if (ch_ok)
         word0 = '{char_code: ch, char_valid: 1'b1, in_value: ch_val,
                    pair_end: 1'b0, message_end: 1'b0, last_of_run: !marker};
      else
         word0 = word1;
      n_push = {1'b0, ch_ok} + {1'b0, marker};
   end

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_take) begin
         wr_ptr_in = wr_ptr_ff + n_push;
         count_in  = count_in + {1'b0, n_push};
      end
      if (rsp_take) begin
         rd_ptr_in = rd_ptr_ff + 2'd1;
         count_in  = count_in - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SEEK_BRACE;
         khc_ff    <= 1'b0;
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         if (req_take) begin
            phase_ff <= phase_in;
            khc_ff   <= khc_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue payload, no reset
   always_ff @(posedge clock) begin
      if (req_take && (n_push != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= word0;
         if (n_push == 2'd2) queue_ff[wr_ptr_ff + 2'd1] <= word1;
      end
   end

   assign rsp_char_code   = queue_ff[rd_ptr_ff].char_code;
   assign rsp_char_valid  = queue_ff[rd_ptr_ff].char_valid;
   assign rsp_in_value    = queue_ff[rd_ptr_ff].in_value;
   assign rsp_pair_end    = queue_ff[rd_ptr_ff].pair_end;
   assign rsp_message_end = queue_ff[rd_ptr_ff].message_end;
   assign rsp_last_of_run = queue_ff[rd_ptr_ff].last_of_run;

endmodule

`default_nettype wire

// ----- hw/rtl/fjsp_checker.sv -----
// fjsp_checker: port-level checks on the result channel of the parser,
// bound to flat_json_string_pair_parser; no package needed
`timescale 1ns / 1ps
`default_nettype none

module fjsp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_char_code,
   input wire logic       rsp_char_valid,
   input wire logic       rsp_in_value,
   input wire logic       rsp_pair_end,
   input wire logic       rsp_message_end,
   input wire logic       rsp_last_of_run
);

   // a stalled word stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_char_code))
      else $error("stalled rsp word dropped or changed");

   // a marker word closes the run of its byte and carries an event
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_valid |->
         rsp_last_of_run && !rsp_in_value && (rsp_pair_end || rsp_message_end))
      else $error("malformed marker word");

   // char words never carry end markers
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_valid |-> !rsp_pair_end && !rsp_message_end)
      else $error("char word with end marker");

   // a char word that is not last is followed by its marker word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_char_valid && !rsp_last_of_run |=>
         rsp_valid && !rsp_char_valid)
      else $error("missing marker after char word");

endmodule

bind flat_json_string_pair_parser fjsp_checker u_fjsp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_char_code   (rsp_char_code),
   .rsp_char_valid  (rsp_char_valid),
   .rsp_in_value    (rsp_in_value),
   .rsp_pair_end    (rsp_pair_end),
   .rsp_message_end (rsp_message_end),
   .rsp_last_of_run (rsp_last_of_run)
);

`default_nettype wire
